FILE: sv/fcq_pkg.sv
// ----------------------------------------------------------------------------
// fcq_pkg: shared definitions for the fixed capacity FIFO queue
// Field widths, request codes, register indexes and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fcq_pkg;

    // fixed field widths
    localparam int DATA_W    = 64;
    localparam int MODE_W    = 3;
    localparam int EB_W      = 4;
    localparam int CFG_IDX_W = 4;

    // parameter defaults
    localparam int DEPTH_DEF     = 16;
    localparam int MAX_BYTES_DEF = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES = CFG_IDX_W'(1);

    // reset values of the configuration registers
    localparam int CAPACITY_RST   = 16;
    localparam int ELEM_BYTES_RST = 1;

    // request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_ENQUEUE = 3'd0,
        MODE_DEQUEUE = 3'd1,
        MODE_PEEK    = 3'd2,
        MODE_FLUSH   = 3'd3,
        MODE_FIND    = 3'd4
    } mode_t;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic load;     // cell at slot takes the write data
        logic shift;    // every cell takes its upper neighbor (dequeue)
        logic rotate;   // shift, and the cell at slot takes the head entry
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/fcq_cell.sv
// ----------------------------------------------------------------------------
// fcq_cell: one storage cell of the queue row
// Holds one entry; loads new data, takes its neighbor's entry or the head.
// ----------------------------------------------------------------------------
`default_nettype none

module fcq_cell #(
    parameter int INDEX  = 0,
    parameter int CNT_W  = 5,
    parameter int ELEM_W = 64
) (
    input  wire                      clk,
    input  wire fcq_pkg::cell_ctrl_t ctl,
    input  wire  [CNT_W-1:0]         slot,
    input  wire  [ELEM_W-1:0]        wdata,
    input  wire  [ELEM_W-1:0]        next_data,
    input  wire  [ELEM_W-1:0]        head_data,
    output logic [ELEM_W-1:0]        data
);
    import fcq_pkg::*;

    logic [ELEM_W-1:0] data_reg;
    logic [ELEM_W-1:0] data_next;
    logic              at_slot;

    assign at_slot = (slot == CNT_W'(INDEX));

    // select the entry for the next cycle
    always_comb
    begin
        data_next = data_reg;
        if (ctl.load && at_slot)
        begin
            data_next = wdata;
        end
        else if (ctl.shift)
        begin
            data_next = next_data;
        end
        else if (ctl.rotate)
        begin
            data_next = at_slot ? head_data : next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: sv/fcq_ctrl.sv
// ----------------------------------------------------------------------------
// fcq_ctrl: request sequencer of the fixed capacity FIFO queue
// Decodes requests, tracks the count, drives the cell row and the results.
// ----------------------------------------------------------------------------
`default_nettype none

module fcq_ctrl #(
    parameter int DEPTH     = fcq_pkg::DEPTH_DEF,
    parameter int MAX_BYTES = fcq_pkg::MAX_BYTES_DEF,
    parameter int CNT_W     = 5,
    parameter int CFG_W     = 5,
    parameter int ELEM_W    = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // request channel
    input  wire                              start,
    output logic                             busy,
    input  wire  [fcq_pkg::MODE_W-1:0]       mode,
    input  wire  [fcq_pkg::DATA_W-1:0]       data_in,
    // result channel
    output logic                             done,
    output logic                             ok,
    output logic [fcq_pkg::DATA_W-1:0]       data_out,
    output logic [CNT_W-1:0]                 count,
    output logic [CNT_W-1:0]                 free_space,
    // configuration channel
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [fcq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [CFG_W-1:0]                 cfg_data,
    // cell row
    input  wire  [ELEM_W-1:0]                head_data,
    output fcq_pkg::cell_ctrl_t              cell_ctl,
    output logic [CNT_W-1:0]                 slot,
    output logic [ELEM_W-1:0]                wdata
);
    import fcq_pkg::*;

    localparam int CAP_RST = (DEPTH < CAPACITY_RST) ? DEPTH : CAPACITY_RST;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t              state_reg,  state_next;
    mode_t               mode_reg,   mode_next;
    logic [ELEM_W-1:0]   key_reg,    key_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [CNT_W-1:0]    cap_reg,    cap_next;
    logic [EB_W-1:0]     eb_reg,     eb_next;
    logic [CNT_W-1:0]    step_reg,   step_next;
    logic                hit_reg,    hit_next;
    logic                done_reg,   done_next;
    logic                ok_reg,     ok_next;
    logic [ELEM_W-1:0]   dout_reg,   dout_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [CNT_W-1:0]    free_reg,   free_next;

    logic [ELEM_W-1:0]   mask;
    logic [CNT_W-1:0]    cap_in;
    logic [EB_W-1:0]     eb_in;
    logic                hit_now;

    // byte mask of the configured element size
    always_comb
    begin
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            mask[8*k +: 8] = {8{EB_W'(k) < eb_reg}};
        end
    end

    // clamp written register values to their legal ranges
    always_comb
    begin
        if (cfg_data == '0)
            cap_in = CNT_W'(1);
        else if (cfg_data > CFG_W'(DEPTH))
            cap_in = CNT_W'(DEPTH);
        else
            cap_in = CNT_W'(cfg_data);

        if (cfg_data[EB_W-1:0] == '0)
            eb_in = EB_W'(1);
        else if (cfg_data[EB_W-1:0] > EB_W'(MAX_BYTES))
            eb_in = EB_W'(MAX_BYTES);
        else
            eb_in = cfg_data[EB_W-1:0];
    end

    assign hit_now = hit_reg | (head_data == key_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        eb_next    = eb_reg;
        step_next  = step_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        dout_next  = dout_reg;
        cnt_next   = cnt_reg;
        free_next  = free_reg;
        cell_ctl   = '0;
        slot       = count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // a write to a listed register empties the queue
                if (cfg_valid)
                begin
                    if (cfg_index == REG_CAPACITY)
                    begin
                        cap_next   = cap_in;
                        count_next = '0;
                    end
                    else if (cfg_index == REG_ELEM_BYTES)
                    begin
                        eb_next    = eb_in;
                        count_next = '0;
                    end
                end
                if (start)
                begin
                    mode_next  = mode_t'(mode);
                    key_next   = data_in[ELEM_W-1:0] & mask;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                ok_next    = 1'b0;
                dout_next  = '0;
                case (mode_reg)
                    MODE_ENQUEUE:
                    begin
                        if (count_reg < cap_reg)
                        begin
                            cell_ctl.load = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            ok_next       = 1'b1;
                        end
                    end
                    MODE_DEQUEUE:
                    begin
                        if (count_reg != '0)
                        begin
                            cell_ctl.shift = 1'b1;
                            dout_next      = head_data;
                            count_next     = count_reg - CNT_W'(1);
                            ok_next        = 1'b1;
                        end
                    end
                    MODE_PEEK:
                    begin
                        if (count_reg != '0)
                        begin
                            dout_next = head_data;
                            ok_next   = 1'b1;
                        end
                    end
                    MODE_FLUSH:
                    begin
                        count_next = '0;
                        ok_next    = 1'b1;
                    end
                    MODE_FIND:
                    begin
                        // walk the held entries past the head cell
                        if (count_reg != '0)
                        begin
                            state_next = ST_SCAN;
                            done_next  = 1'b0;
                            step_next  = '0;
                            hit_next   = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                cnt_next  = count_next;
                free_next = cap_reg - count_next;
            end

            ST_SCAN:
            begin
                // one rotation per cycle; count rotations restore the order
                cell_ctl.rotate = 1'b1;
                slot            = count_reg - CNT_W'(1);
                hit_next        = hit_now;
                step_next       = step_reg + CNT_W'(1);
                if (step_reg == count_reg - CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = hit_now;
                    cnt_next   = count_reg;
                    free_next  = cap_reg - count_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cap_reg   <= CNT_W'(CAP_RST);
            eb_reg    <= EB_W'(ELEM_BYTES_RST);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            eb_reg    <= eb_next;
            done_reg  <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        key_reg  <= key_next;
        step_reg <= step_next;
        hit_reg  <= hit_next;
        ok_reg   <= ok_next;
        dout_reg <= dout_next;
        cnt_reg  <= cnt_next;
        free_reg <= free_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign data_out   = DATA_W'(dout_reg);
    assign count      = cnt_reg;
    assign free_space = free_reg;
    assign wdata      = key_reg;

endmodule

`default_nettype wire

FILE: sv/fixed_capacity_fifo_queue.sv
// ----------------------------------------------------------------------------
// fixed_capacity_fifo_queue: configurable FIFO built from a row of cells
// Enqueue, dequeue, peek, flush and find on up to DEPTH elements.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive mode and data_in with start high; the request transfers
//   at the clock edge where start is high and busy is low.
//   Result: done pulses for one cycle with ok, data_out, count and
//   free_space valid. The receiver cannot stall; it must take it then.
//   Configuration: cfg_valid/cfg_ready write channel; index 0 is capacity,
//   index 1 is element size in bytes. A write to either register empties the queue.
//   Other indexes are ignored. cfg_ready is high whenever the block is idle.
// Sequencing:
//   Enqueue, dequeue, peek, flush and unused modes: the request runs in the
//   execute state and done follows; busy is high until the request is through.
//   Find: the held entries rotate through the cell row one step per cycle and
//   are compared at the head cell.
// Entries sit oldest first in the cell row; a dequeue shifts the whole row.
// Reset empties the queue and restores capacity 16 (or DEPTH if smaller) and
// element size 1. The cell row itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_capacity_fifo_queue #(
    parameter int DEPTH     = fcq_pkg::DEPTH_DEF,
    parameter int MAX_BYTES = fcq_pkg::MAX_BYTES_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int CFG_W    = (CNT_W > 5) ? CNT_W : 5
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [fcq_pkg::MODE_W-1:0]       mode,
    input  wire  [fcq_pkg::DATA_W-1:0]       data_in,
    output logic                             done,
    output logic                             ok,
    output logic [fcq_pkg::DATA_W-1:0]       data_out,
    output logic [CNT_W-1:0]                 count,
    output logic [CNT_W-1:0]                 free_space,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [fcq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [CFG_W-1:0]                 cfg_data
);
    import fcq_pkg::*;

    localparam int ELEM_W = 8 * MAX_BYTES;

    cell_ctrl_t          cell_ctl;
    logic [CNT_W-1:0]    slot;
    logic [ELEM_W-1:0]   wdata;
    logic [ELEM_W-1:0]   cell_data [DEPTH];
    logic [ELEM_W-1:0]   cell_next [DEPTH];

    fcq_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BYTES (MAX_BYTES),
        .CNT_W     (CNT_W),
        .CFG_W     (CFG_W),
        .ELEM_W    (ELEM_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .data_in    (data_in),
        .done       (done),
        .ok         (ok),
        .data_out   (data_out),
        .count      (count),
        .free_space (free_space),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_data  (cell_data[0]),
        .cell_ctl   (cell_ctl),
        .slot       (slot),
        .wdata      (wdata)
    );

    // row of cells, each fed by its upper neighbor; the last one is fed zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_last
            assign cell_next[i] = '0;
        end
        else
        begin : g_mid
            assign cell_next[i] = cell_data[i + 1];
        end

        fcq_cell #(
            .INDEX  (i),
            .CNT_W  (CNT_W),
            .ELEM_W (ELEM_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .slot      (slot),
            .wdata     (wdata),
            .next_data (cell_next[i]),
            .head_data (cell_data[0]),
            .data      (cell_data[i])
        );
    end

    // a transferred request always makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not start processing");

    // results never come in consecutive cycles
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // processing ends exactly when a result appears
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("processing ended without a result");

    // a refused request returns no data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (data_out == '0))
        else $error("refused request returned data");

endmodule

`default_nettype wire

FILE: tb/fixed_capacity_fifo_queue_test.sv
// ----------------------------------------------------------------------------
// fixed_capacity_fifo_queue_test: self-checking bench for the FIFO queue
// A clocked driver works through a planned list of requests and register
// writes. Each accepted request runs through a software copy of the queue,
// which gives the expected response. A monitor compares every done pulse
// with the oldest expected response. A directed opening is followed by
// random phases, each with its own capacity, element size and idle rate.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_capacity_fifo_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fcq_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int MAX_BYTES     = MAX_BYTES_DEF;
    localparam int CNT_W         = 5;
    localparam int CFG_W         = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 135;

    // codes the package leaves out
    localparam logic [MODE_W-1:0]    MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0]    MODE_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE  = 4'hF;

    typedef enum logic {OP_REQUEST, OP_REG_WRITE} op_kind_t;

    typedef struct {
        op_kind_t              kind;
        int unsigned           idle_pct;
        logic [MODE_W-1:0]     mode;
        logic [DATA_W-1:0]     data;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
    } fifo_op_t;

    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  free;
    } fifo_resp_t;

    // driven bench signals, known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [MODE_W-1:0]     mode      = '0;
    logic [DATA_W-1:0]     data_in   = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  busy;
    logic                  done;
    logic                  ok;
    logic [DATA_W-1:0]     data_out;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      free_space;
    logic                  cfg_ready;

    fifo_op_t    op_plan [$];
    fifo_resp_t  awaited_responses [$];
    int unsigned plan_idle_pct = 0;
    int          in_flight     = 0;
    int          quiet_cycles  = 0;
    int          error_count   = 0;

    // software copy of the queue
    logic [DATA_W-1:0]    store_copy [DEPTH];
    logic [3:0]           head_q;
    logic [3:0]           tail_q;
    logic [CNT_W-1:0]     held_q;
    logic [CNT_W-1:0]     capacity_reg;
    logic [EB_W-1:0]      elem_bytes_reg;

    fixed_capacity_fifo_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .data_in    (data_in),
        .done       (done),
        .ok         (ok),
        .data_out   (data_out),
        .count      (count),
        .free_space (free_space),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [3:0] ring_next(logic [3:0] idx, int unsigned cap);
        int unsigned n;
        n = int'(idx) + 1;
        return (n >= cap) ? 4'd0 : 4'(n);
    endfunction

    // one request against the queue copy; returns the response it must give
    task automatic queue_response(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] d,
                                  output fifo_resp_t r);
        int unsigned       cap;
        int unsigned       nbytes;
        int unsigned       i;
        logic [3:0]        idx;
        logic [DATA_W-1:0] mask;
        cap    = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        nbytes = (elem_bytes_reg == 0) ? 1 :
                 (elem_bytes_reg > MAX_BYTES) ? MAX_BYTES : elem_bytes_reg;
        mask   = (nbytes >= 8) ? '1 : ((64'd1 << (nbytes * 8)) - 64'd1);
        r.ok   = 1'b0;
        r.data = '0;
        case (m)
            MODE_ENQUEUE:
                if (held_q < cap)
                begin
                    store_copy[tail_q] = d & mask;
                    tail_q = ring_next(tail_q, cap);
                    held_q = held_q + 1'b1;
                    r.ok   = 1'b1;
                end
            MODE_DEQUEUE:
                if (held_q != 0)
                begin
                    r.data = store_copy[head_q] & mask;
                    head_q = ring_next(head_q, cap);
                    held_q = held_q - 1'b1;
                    r.ok   = 1'b1;
                end
            MODE_PEEK:
                if (held_q != 0)
                begin
                    r.data = store_copy[head_q] & mask;
                    r.ok   = 1'b1;
                end
            MODE_FLUSH:
            begin
                head_q = '0;
                tail_q = '0;
                held_q = '0;
                r.ok   = 1'b1;
            end
            MODE_FIND:
            begin
                // oldest to newest, exact match under the element mask
                idx = head_q;
                for (i = 0; i < held_q && !r.ok; i++)
                begin
                    if ((store_copy[idx] & mask) == (d & mask))
                        r.ok = 1'b1;
                    idx = ring_next(idx, cap);
                end
            end
            default: ;
        endcase
        r.count = held_q;
        r.free  = CNT_W'(cap - held_q);
    endtask

    // register write: listed registers also empty the queue
    task automatic apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        if (idx == REG_CAPACITY || idx == REG_ELEM_BYTES)
        begin
            if (idx == REG_CAPACITY)
                capacity_reg = val;
            else
                elem_bytes_reg = val[EB_W-1:0];
            head_q = '0;
            tail_q = '0;
            held_q = '0;
        end
    endtask

    // driver: presents planned requests and register writes
    always @(posedge clk or negedge rst_n)
    begin
        fifo_op_t   op;
        fifo_resp_t r;
        logic       start_nx;
        logic       cfg_valid_nx;
        if (!rst_n)
        begin
            start          <= 1'b0;
            mode           <= '0;
            data_in        <= '0;
            cfg_valid      <= 1'b0;
            cfg_index      <= '0;
            cfg_data       <= '0;
            in_flight      = 0;
            quiet_cycles   = 0;
            head_q         = '0;
            tail_q         = '0;
            held_q         = '0;
            capacity_reg   = CNT_W'(CAPACITY_RST);
            elem_bytes_reg = EB_W'(ELEM_BYTES_RST);
        end
        else
        begin
            start_nx     = start;
            cfg_valid_nx = cfg_valid;
            if (start && !busy)
            begin
                queue_response(mode, data_in, r);
                awaited_responses.push_back(r);
                in_flight++;
                start_nx = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_reg_write(cfg_index, cfg_data);
                cfg_valid_nx = 1'b0;
            end
            if (done)
                in_flight--;
            quiet_cycles = (in_flight == 0 && !start_nx && !cfg_valid_nx) ?
                           quiet_cycles + 1 : 0;
            // next transfer; register writes only once the block has settled
            if (!start_nx && !cfg_valid_nx && op_plan.size() != 0)
            begin
                op = op_plan[0];
                if (op.kind == OP_REQUEST)
                begin
                    if ($urandom_range(99) >= op.idle_pct)
                    begin
                        void'(op_plan.pop_front());
                        start_nx = 1'b1;
                        mode     <= op.mode;
                        data_in  <= op.data;
                    end
                end
                else if (quiet_cycles >= SETTLE_CYCLES)
                begin
                    void'(op_plan.pop_front());
                    cfg_valid_nx = 1'b1;
                    cfg_index    <= op.reg_idx;
                    cfg_data     <= op.reg_val;
                end
            end
            start     <= start_nx;
            cfg_valid <= cfg_valid_nx;
        end
    end

    // monitor: every done pulse against the oldest expected response
    always @(posedge clk)
    begin
        fifo_resp_t want;
        if (rst_n && done)
        begin
            if (awaited_responses.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected response: ok=%0d data=%h count=%0d free=%0d",
                             ok, data_out, count, free_space);
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (ok !== want.ok || data_out !== want.data ||
                    count !== want.count || free_space !== want.free)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"mismatch: exp ok=%0d data=%h count=%0d free=%0d",
                                  " / got ok=%0d data=%h count=%0d free=%0d"},
                                 want.ok, want.data, want.count, want.free,
                                 ok, data_out, count, free_space);
                end
            end
        end
    end

    task automatic add_request(logic [MODE_W-1:0] m, logic [DATA_W-1:0] d);
        fifo_op_t op;
        op.kind     = OP_REQUEST;
        op.idle_pct = plan_idle_pct;
        op.mode     = m;
        op.data     = d;
        op.reg_idx  = '0;
        op.reg_val  = '0;
        op_plan.push_back(op);
    endtask

    task automatic add_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        fifo_op_t op;
        op.kind     = OP_REG_WRITE;
        op.idle_pct = 0;
        op.mode     = '0;
        op.data     = '0;
        op.reg_idx  = idx;
        op.reg_val  = val;
        op_plan.push_back(op);
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random requests in bursts that lean to filling, draining or neither
    task automatic add_random_phase(int unsigned n);
        logic [DATA_W-1:0] recent [$];
        logic [DATA_W-1:0] w;
        int unsigned       k;
        int unsigned       roll;
        int unsigned       enq_cut;
        int unsigned       deq_cut;
        for (k = 0; k < n; k++)
        begin
            if (k % 16 == 0)
            begin
                case ($urandom_range(2))
                    0:       begin enq_cut = 62; deq_cut = 74; end
                    1:       begin enq_cut = 15; deq_cut = 65; end
                    default: begin enq_cut = 35; deq_cut = 65; end
                endcase
            end
            roll = $urandom_range(99);
            w    = random_word();
            if (roll < enq_cut)
            begin
                add_request(MODE_ENQUEUE, w);
                recent.push_back(w);
                if (recent.size() > 8)
                    void'(recent.pop_front());
            end
            else if (roll < deq_cut)
                add_request(MODE_DEQUEUE, w);
            else if (roll < deq_cut + 8)
                add_request(MODE_PEEK, w);
            else if (roll < 92)
            begin
                // mostly search for something recently queued, upper half
                // sometimes disturbed to probe the element mask
                if (recent.size() != 0 && $urandom_range(9) < 6)
                begin
                    w = recent[$urandom_range(recent.size() - 1)];
                    if ($urandom_range(1))
                        w[63:32] = $urandom;
                end
                add_request(MODE_FIND, w);
            end
            else if (roll < 95)
                add_request(MODE_FLUSH, w);
            else
                add_request(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), w);
        end
    endtask

    task automatic start_phase(int unsigned idle, logic [CFG_W-1:0] cap, logic [CFG_W-1:0] eb);
        plan_idle_pct = idle;
        add_reg_write(REG_CAPACITY, cap);
        add_reg_write(REG_ELEM_BYTES, eb);
        if ($urandom_range(1))
            add_reg_write(4'($urandom_range(REG_ELEM_BYTES + 1, REG_LAST_CODE)), 5'($urandom));
    endtask

    // stimulus plan, reset and end of run
    initial
    begin
        int unsigned idle_mix [3];
        int unsigned ph;
        logic [CFG_W-1:0] cap_val;
        logic [CFG_W-1:0] eb_val;
        idle_mix = '{0, 71, 13};

        // directed: empty queue, unused modes, one-byte masking, flush
        add_request(MODE_DEQUEUE, '0);
        add_request(MODE_PEEK, '1);
        add_request(MODE_FIND, '0);
        add_request(MODE_UNUSED_LO, '1);
        add_request(MODE_UNUSED_HI - 1'b1, '1);
        add_request(MODE_UNUSED_HI, '0);
        add_request(MODE_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(MODE_ENQUEUE, 64'h0);
        add_request(MODE_ENQUEUE, 64'h1234_5678_9ABC_DEA5);
        add_request(MODE_PEEK, '0);
        add_request(MODE_FIND, 64'h0000_0000_0000_00A5);
        add_request(MODE_FIND, 64'h5A5A_5A5A_5A5A_5AA5);
        add_request(MODE_FIND, 64'h0000_0000_0000_0077);
        add_request(MODE_DEQUEUE, '0);
        add_request(MODE_DEQUEUE, '0);
        add_request(MODE_PEEK, '0);
        add_request(MODE_FLUSH, '1);
        add_request(MODE_DEQUEUE, '0);
        add_request(MODE_PEEK, '0);

        // two-entry ring, full width; unlisted register leaves contents alone
        add_reg_write(REG_CAPACITY, 5'd2);
        add_reg_write(REG_ELEM_BYTES, 5'd8);
        add_request(MODE_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(MODE_ENQUEUE, 64'h8000_0000_0000_0001);
        add_reg_write(REG_LAST_CODE, 5'h1F);
        add_request(MODE_ENQUEUE, 64'h0000_0000_0000_0123);
        add_request(MODE_FIND, 64'h8000_0000_0000_0001);
        add_request(MODE_DEQUEUE, '0);
        add_request(MODE_ENQUEUE, 64'hDEAD_BEEF_0BAD_F00D);
        add_request(MODE_DEQUEUE, '0);
        add_request(MODE_DEQUEUE, '0);
        add_request(MODE_DEQUEUE, '0);

        // random phases over capacity and element size, including out of range
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       begin cap_val = 5'd16; eb_val = 5'd8;  end
                1:       begin cap_val = 5'd1;  eb_val = 5'd1;  end
                2:       begin cap_val = 5'd0;  eb_val = 5'd0;  end
                3:       begin cap_val = 5'd31; eb_val = 5'd15; end
                4:       begin cap_val = 5'($urandom_range(1, 16));
                               eb_val  = 5'($urandom_range(1, 8)); end
                5:       begin cap_val = 5'd3;  eb_val = 5'd4;  end
                6:       begin cap_val = 5'($urandom); eb_val = 5'($urandom); end
                default: begin cap_val = 5'd16; eb_val = 5'd2;  end
            endcase
            start_phase(idle_mix[ph % 3], cap_val, eb_val);
            add_random_phase(PHASE_ITEMS);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (op_plan.size() != 0 || start || cfg_valid || in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        error_count += awaited_responses.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
